### hdl/bmrf_pkg.sv
// Package for the bitmap rectangle fill block: sizes, widths, command codes
// and the configuration view shared by the modules. No dependencies.
`timescale 1ns / 1ps
package bmrf_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;
  localparam int WORD_BITS  = 64;
  localparam int NWORDS     = (MAX_WIDTH * MAX_HEIGHT + WORD_BITS - 1) / WORD_BITS;

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int ADDR_W = $clog2(NWORDS);
  localparam int PIX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int CW_W   = 10;  // buffer_width register
  localparam int CH_W   = 9;   // buffer_height register

  // field widths of the command transaction
  localparam int CMD_W  = 3;
  localparam int PX_W   = 9;
  localparam int PY_W   = 8;
  localparam int BW_W   = 10;
  localparam int BH_W   = 9;
  localparam int WI_W   = 11;

  // APB register map
  localparam int PADDR_W = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_MASK_PT   = 3'd0,
    CMD_MASK_RECT = 3'd1,
    CMD_MASK_ALL  = 3'd2,
    CMD_DIRTY_PT  = 3'd3,
    CMD_DIRTY_RECT= 3'd4,
    CMD_DIRTY_ALL = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_READ      = 3'd7
  } cmd_e;

  // configuration seen by the fill engine
  typedef struct packed {
    logic [CW_W-1:0]  width;
    logic [CH_W-1:0]  height;
    logic [PIX_W-1:0] pix_count;
    logic             reinit;     // one-cycle pulse on a register write
  } cfg_t;

endpackage

### hdl/bmrf_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on bmrf_pkg.
`timescale 1ns / 1ps
interface bmrf_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [bmrf_pkg::CMD_W-1:0] cmd;
  logic [bmrf_pkg::PX_W-1:0]  pos_x;
  logic [bmrf_pkg::PY_W-1:0]  pos_y;
  logic [bmrf_pkg::BW_W-1:0]  box_width;
  logic [bmrf_pkg::BH_W-1:0]  box_height;
  logic                       fill_value;
  logic [bmrf_pkg::WI_W-1:0]  word_index;

  modport source (output valid, cmd, pos_x, pos_y, box_width, box_height,
                  fill_value, word_index, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, box_width, box_height,
                  fill_value, word_index, output ready);
endinterface

interface bmrf_res_if;
  logic                           valid;
  logic                           ready;
  logic [bmrf_pkg::WORD_BITS-1:0] mask_word;
  logic [bmrf_pkg::WORD_BITS-1:0] dirty_word;
  logic                           changes_pending;

  modport source (output valid, mask_word, dirty_word, changes_pending, input ready);
  modport sink   (input valid, mask_word, dirty_word, changes_pending, output ready);
endinterface

### hdl/bitmap_rect_fill.sv
// Top level of the bitmap rectangle fill block: register block and fill
// engine. Depends on bmrf_pkg, bmrf_if, bmrf_cfg and bmrf_engine.
//
// Usage: commands arrive as transactions on cmd_i, one result transaction
// per command leaves on res_o. Both maps live in two 64-bit x 2048 RAMs.
// After acceptance, a clear, a point outside the buffer or an empty
// rectangle goes straight to the result; a point or a rectangle reads each
// word it touches and writes it back through the RAM port, a read fetches
// one word, and a whole-map fill writes every word. The next command is
// accepted once the engine is back in idle; a finished result waits in the
// output register. At reset, and after every write of buffer_width or
// buffer_height over APB, a clearing pass over every word rewrites both maps
// (pixel bits set, others zero); cmd_i is not ready meanwhile. If res_o is
// stalled, the engine still takes one more command, then holds its result.
// Registers: buffer_width at 0x0, buffer_height at 0x4; pready always high.
`timescale 1ns / 1ps
module bitmap_rect_fill (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bmrf_cmd_if.sink                     cmd_i,
  bmrf_res_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmrf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bmrf_pkg::*;

  cfg_t cfg;

  bmrf_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg));

  bmrf_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_i, .res_o);
endmodule

### hdl/bmrf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bmrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/bmrf_cfg.sv
// APB register block: buffer width and height, saturated on write.
// Depends on bmrf_pkg.
`timescale 1ns / 1ps
module bmrf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmrf_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bmrf_pkg::cfg_t                cfg_o
);
  import bmrf_pkg::*;

  logic [CW_W-1:0] width_q, width_d;
  logic [CH_W-1:0] height_q, height_d;
  logic            reinit_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // saturate the written values into the legal range
  always_comb begin
    width_d  = pwdata[CW_W-1:0];
    height_d = pwdata[CH_W-1:0];
    if (width_d == '0) width_d = CW_W'(1);
    else if (width_d > CW_W'(MAX_WIDTH)) width_d = CW_W'(MAX_WIDTH);
    if (height_d == '0) height_d = CH_W'(1);
    else if (height_d > CH_W'(MAX_HEIGHT)) height_d = CH_W'(MAX_HEIGHT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW_W'(MAX_WIDTH);
      height_q <= CH_W'(MAX_HEIGHT);
      reinit_q <= 1'b0;
    end else begin
      reinit_q <= wr_en;
      if (wr_en) begin
        if (paddr[2] == REG_WIDTH) width_q  <= width_d;
        else                       height_q <= height_d;
      end
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WIDTH) prdata[CW_W-1:0] = width_q;
    else                       prdata[CH_W-1:0] = height_q;
  end

  assign cfg_o.width     = width_q;
  assign cfg_o.height    = height_q;
  assign cfg_o.pix_count = PIX_W'(width_q) * PIX_W'(height_q);
  assign cfg_o.reinit    = reinit_q;
endmodule

### hdl/bmrf_engine.sv
// Fill engine: read-modify-write sequencer over the mask and dirty RAMs,
// plus the pending flag and the result register. Depends on bmrf_pkg,
// bmrf_if and bmrf_ram.
`timescale 1ns / 1ps
module bmrf_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bmrf_pkg::cfg_t cfg_i,
  bmrf_cmd_if.sink       cmd_i,
  bmrf_res_if.source     res_o
);
  import bmrf_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PT_RD, ST_PT_WR, ST_RECT_RD, ST_RECT_WR,
    ST_ALL, ST_RD, ST_FIN
  } state_e;

  state_e              state_q;
  cmd_e                cmd_q;
  logic                val_q;
  logic                flag_q;
  logic                reinit_q;
  logic [ADDR_W-1:0]   cnt_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [BIT_W-1:0]    bit_q;
  logic [PIX_W-1:0]    lo_q, hi_q, base_q;
  logic [PX_W-1:0]     x0_q;
  logic [CW_W-1:0]     x1_q;
  logic [CH_W-1:0]     row_q, y1_q;
  logic                out_valid_q;
  logic [WORD_BITS-1:0] out_mask_q, out_dirty_q;
  logic                out_flag_q;

  // RAM ports
  logic                 we_m, we_dy, re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [WORD_BITS-1:0] wdata_m, wdata_dy, rdata_m, rdata_dy;

  bmrf_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_mask_ram (
    .clk_i, .we_i(we_m), .waddr_i(waddr), .wdata_i(wdata_m),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata_m));

  bmrf_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_dirty_ram (
    .clk_i, .we_i(we_dy), .waddr_i(waddr), .wdata_i(wdata_dy),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata_dy));

  // pixel bits of word w for a buffer of n pixels
  function automatic logic [WORD_BITS-1:0] pix_mask(logic [ADDR_W-1:0] w,
                                                    logic [PIX_W-1:0] n);
    logic [PIX_W-1:0] wb;
    logic [PIX_W-1:0] off;
    wb  = PIX_W'({w, {BIT_W{1'b0}}});
    off = n - wb;
    if (n >= wb + PIX_W'(WORD_BITS)) pix_mask = '1;
    else if (n <= wb)                pix_mask = '0;
    else pix_mask = (WORD_BITS'(1) << off[BIT_W-1:0]) - WORD_BITS'(1);
  endfunction

  // command decode at acceptance
  logic                 accept, pt_in;
  logic [PIX_W-1:0]     p_lin, row_base;
  logic [CW_W:0]        x_end;
  logic [CH_W:0]        y_end;
  logic [CW_W-1:0]      x1_c;
  logic [CH_W-1:0]      y1_c;

  // a register write blocks commands from the cycle after it lands
  assign cmd_i.ready = (state_q == ST_IDLE) && !reinit_q && !cfg_i.reinit;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    pt_in    = (CW_W'(cmd_i.pos_x) < cfg_i.width) && (CH_W'(cmd_i.pos_y) < cfg_i.height);
    row_base = PIX_W'(cmd_i.pos_y) * PIX_W'(cfg_i.width);
    p_lin    = row_base + PIX_W'(cmd_i.pos_x);
    x_end    = (CW_W+1)'(cmd_i.pos_x) + (CW_W+1)'(cmd_i.box_width);
    y_end    = (CH_W+1)'(cmd_i.pos_y) + (CH_W+1)'(cmd_i.box_height);
    x1_c     = (x_end > (CW_W+1)'(cfg_i.width))  ? cfg_i.width  : x_end[CW_W-1:0];
    y1_c     = (y_end > (CH_W+1)'(cfg_i.height)) ? cfg_i.height : y_end[CH_W-1:0];
  end

  // span word under the rectangle walk
  logic [PIX_W-1:0]     wbase, wend, lo_next;
  logic [PIX_W-1:0]     hi_off;
  logic [WORD_BITS-1:0] rect_sel, sel, pm;
  logic                 mask_cmd;

  always_comb begin
    wbase    = {lo_q[PIX_W-1:BIT_W], {BIT_W{1'b0}}};
    wend     = wbase + PIX_W'(WORD_BITS);
    hi_off   = hi_q - wbase;
    lo_next  = (hi_q <= wend) ? hi_q : wend;
    rect_sel = {WORD_BITS{1'b1}} << lo_q[BIT_W-1:0];
    if (hi_q < wend)
      rect_sel = rect_sel & ((WORD_BITS'(1) << hi_off[BIT_W-1:0]) - WORD_BITS'(1));
    sel      = (state_q == ST_PT_WR) ? (WORD_BITS'(1) << bit_q) : rect_sel;
    mask_cmd = (cmd_q == CMD_MASK_PT) || (cmd_q == CMD_MASK_RECT) || (cmd_q == CMD_MASK_ALL);
  end

  // RAM control
  always_comb begin
    we_m     = 1'b0;
    we_dy    = 1'b0;
    re       = 1'b0;
    waddr    = cnt_q;
    raddr    = addr_q;
    wdata_m  = '0;
    wdata_dy = '0;
    pm       = pix_mask(cnt_q, cfg_i.pix_count);
    case (state_q)
      ST_INIT: begin
        we_m     = 1'b1;
        we_dy    = 1'b1;
        wdata_m  = pm;
        wdata_dy = pm;
      end
      ST_ALL: begin
        we_dy = 1'b1;
        if (mask_cmd) begin
          we_m     = 1'b1;
          wdata_m  = val_q ? pm : '0;
          wdata_dy = pm;
        end else begin
          wdata_dy = val_q ? pm : '0;
        end
      end
      ST_PT_RD, ST_RD: re = 1'b1;
      ST_RECT_RD: begin
        re    = 1'b1;
        raddr = lo_q[BIT_W+ADDR_W-1:BIT_W];
      end
      ST_PT_WR, ST_RECT_WR: begin
        waddr = (state_q == ST_PT_WR) ? addr_q : lo_q[BIT_W+ADDR_W-1:BIT_W];
        we_dy = 1'b1;
        if (mask_cmd) begin
          we_m     = 1'b1;
          wdata_m  = val_q ? (rdata_m | sel) : (rdata_m & ~sel);
          wdata_dy = rdata_dy | sel;
        end else begin
          wdata_dy = val_q ? (rdata_dy | sel) : (rdata_dy & ~sel);
        end
      end
      default: ;
    endcase
  end

  // sequencer, flag and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      flag_q      <= 1'b1;
      reinit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.reinit) begin
        reinit_q <= 1'b1;
        flag_q   <= 1'b1;
      end
      if (res_o.valid && res_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + ADDR_W'(1);
          if (cnt_q == ADDR_W'(NWORDS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (reinit_q) begin
            reinit_q <= 1'b0;
            cnt_q    <= '0;
            state_q  <= ST_INIT;
          end else if (accept) begin
            cmd_q  <= cmd_e'(cmd_i.cmd);
            val_q  <= cmd_i.fill_value;
            addr_q <= cmd_i.word_index;
            cnt_q  <= '0;
            state_q <= ST_FIN;
            case (cmd_e'(cmd_i.cmd))
              CMD_MASK_PT, CMD_DIRTY_PT: begin
                if (pt_in) begin
                  flag_q  <= 1'b1;
                  addr_q  <= p_lin[BIT_W+ADDR_W-1:BIT_W];
                  bit_q   <= p_lin[BIT_W-1:0];
                  state_q <= ST_PT_RD;
                end
              end
              CMD_MASK_RECT, CMD_DIRTY_RECT: begin
                flag_q <= 1'b1;
                x0_q   <= cmd_i.pos_x;
                x1_q   <= x1_c;
                y1_q   <= y1_c;
                row_q  <= CH_W'(cmd_i.pos_y);
                base_q <= row_base;
                lo_q   <= p_lin;
                hi_q   <= row_base + PIX_W'(x1_c);
                if ((CW_W'(cmd_i.pos_x) < x1_c) && (CH_W'(cmd_i.pos_y) < y1_c))
                  state_q <= ST_RECT_RD;
              end
              CMD_MASK_ALL, CMD_DIRTY_ALL: begin
                flag_q  <= 1'b1;
                state_q <= ST_ALL;
              end
              CMD_CLEAR: flag_q <= 1'b0;
              CMD_READ:  state_q <= ST_RD;
              default: ;
            endcase
          end
        end
        ST_PT_RD:   state_q <= ST_PT_WR;
        ST_PT_WR:   state_q <= ST_FIN;
        ST_RECT_RD: state_q <= ST_RECT_WR;
        ST_RECT_WR: begin
          // next word of this row, or the next row
          state_q <= ST_RECT_RD;
          if (lo_next == hi_q) begin
            row_q  <= row_q + CH_W'(1);
            base_q <= base_q + PIX_W'(cfg_i.width);
            lo_q   <= base_q + PIX_W'(cfg_i.width) + PIX_W'(x0_q);
            hi_q   <= base_q + PIX_W'(cfg_i.width) + PIX_W'(x1_q);
            if (row_q + CH_W'(1) == y1_q) state_q <= ST_FIN;
          end else begin
            lo_q <= lo_next;
          end
        end
        ST_ALL: begin
          cnt_q <= cnt_q + ADDR_W'(1);
          if (cnt_q == ADDR_W'(NWORDS - 1)) state_q <= ST_FIN;
        end
        ST_RD: state_q <= ST_FIN;
        ST_FIN: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_flag_q  <= flag_q;
            out_mask_q  <= (cmd_q == CMD_READ) ? rdata_m  : '0;
            out_dirty_q <= (cmd_q == CMD_READ) ? rdata_dy : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.mask_word       = out_mask_q;
  assign res_o.dirty_word      = out_dirty_q;
  assign res_o.changes_pending = out_flag_q;
endmodule

### sim/bitmap_rect_fill_tb.sv
// Self-checking testbench for bitmap_rect_fill: directed and random command
// streams with a bit-level map predictor. Depends on bmrf_pkg, bmrf_if and bitmap_rect_fill.
`timescale 1ns / 1ps
module bitmap_rect_fill_tb;
  import bmrf_pkg::*;

  typedef struct {
    cmd_e             op;
    logic [PX_W-1:0]  x;
    logic [PY_W-1:0]  y;
    logic [BW_W-1:0]  w;
    logic [BH_W-1:0]  h;
    logic             v;
    logic [WI_W-1:0]  wi;
  } fill_cmd_t;

  typedef struct {
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] dirty;
    logic                 pending;
  } map_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bmrf_cmd_if cmd_if ();
  bmrf_res_if res_if ();

  bitmap_rect_fill dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_if), .res_o(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted block state
  logic [WORD_BITS-1:0] mask_model [NWORDS];
  logic [WORD_BITS-1:0] dirty_model [NWORDS];
  int unsigned cur_width, cur_height;
  bit pending_model;

  map_word_t expected_words[$];
  int errors = 0;
  bit calm = 1'b0;  // no idling on either side while set

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // write bits [lo, hi) of one map
  function automatic void put_span(bit dirty, int unsigned lo, int unsigned hi, bit v);
    int unsigned w, b, take;
    logic [WORD_BITS-1:0] sel;
    while (lo < hi) begin
      w = lo / WORD_BITS;
      b = lo % WORD_BITS;
      take = WORD_BITS - b;
      if (hi - lo < take) take = hi - lo;
      sel = (take >= 64) ? '1 : (((64'd1 << take) - 64'd1) << b);
      if (w < NWORDS) begin
        if (dirty) dirty_model[w] = v ? (dirty_model[w] | sel) : (dirty_model[w] & ~sel);
        else mask_model[w] = v ? (mask_model[w] | sel) : (mask_model[w] & ~sel);
      end
      lo += take;
    end
  endfunction

  function automatic void put_whole(bit dirty, bit v);
    for (int i = 0; i < NWORDS; i++) begin
      if (dirty) dirty_model[i] = '0;
      else mask_model[i] = '0;
    end
    if (v) put_span(dirty, 0, cur_width * cur_height, 1'b1);
  endfunction

  function automatic void put_box(bit dirty, int unsigned x, int unsigned y,
                                  int unsigned w, int unsigned h, bit v);
    int unsigned x1, y1;
    x1 = x + w;
    y1 = y + h;
    if (x1 > cur_width) x1 = cur_width;
    if (y1 > cur_height) y1 = cur_height;
    if (x >= x1 || y >= y1) return;
    for (int unsigned r = y; r < y1; r++)
      put_span(dirty, r * cur_width + x, r * cur_width + x1, v);
  endfunction

  function automatic void restart_maps();
    put_whole(1'b0, 1'b1);
    put_whole(1'b1, 1'b1);
    pending_model = 1'b1;
  endfunction

  // apply one command to the model and return the word it should answer with
  function automatic map_word_t apply_fill_cmd(fill_cmd_t c);
    map_word_t r;
    bit in_buf;
    int unsigned p;
    in_buf = (c.x < cur_width) && (c.y < cur_height);
    p = c.y * cur_width + c.x;
    r.mask = '0;
    r.dirty = '0;
    case (c.op)
      CMD_MASK_PT: begin
        if (in_buf) begin
          put_span(1'b0, p, p + 1, c.v);
          put_span(1'b1, p, p + 1, 1'b1);
          pending_model = 1'b1;
        end
      end
      CMD_MASK_RECT: begin
        put_box(1'b0, c.x, c.y, c.w, c.h, c.v);
        put_box(1'b1, c.x, c.y, c.w, c.h, 1'b1);
        pending_model = 1'b1;
      end
      CMD_MASK_ALL: begin
        put_whole(1'b0, c.v);
        put_whole(1'b1, 1'b1);
        pending_model = 1'b1;
      end
      CMD_DIRTY_PT: begin
        if (in_buf) begin
          put_span(1'b1, p, p + 1, c.v);
          pending_model = 1'b1;
        end
      end
      CMD_DIRTY_RECT: begin
        put_box(1'b1, c.x, c.y, c.w, c.h, c.v);
        pending_model = 1'b1;
      end
      CMD_DIRTY_ALL: begin
        put_whole(1'b1, c.v);
        pending_model = 1'b1;
      end
      CMD_CLEAR: pending_model = 1'b0;
      default: begin
        if (c.wi < NWORDS) begin
          r.mask = mask_model[c.wi];
          r.dirty = dirty_model[c.wi];
        end
      end
    endcase
    r.pending = pending_model;
    return r;
  endfunction

  // send one command transaction; valid stays high for back-to-back sends
  task automatic send_cmd(fill_cmd_t c);
    if (!calm && $urandom_range(99) < 28) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 28);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd <= c.op;
    cmd_if.pos_x <= c.x;
    cmd_if.pos_y <= c.y;
    cmd_if.box_width <= c.w;
    cmd_if.box_height <= c.h;
    cmd_if.fill_value <= c.v;
    cmd_if.word_index <= c.wi;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    expected_words.push_back(apply_fill_cmd(c));
  endtask

  task automatic send_fields(cmd_e op, int x, int y, int w, int h, bit v, int wi);
    fill_cmd_t c;
    c.op = op;
    c.x = PX_W'(x);
    c.y = PY_W'(y);
    c.w = BW_W'(w);
    c.h = BH_W'(h);
    c.v = v;
    c.wi = WI_W'(wi);
    send_cmd(c);
  endtask

  // stop sending and let the block go idle
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write, then mirror the saturating register update
  task automatic write_reg(int unsigned idx, logic [31:0] value);
    int unsigned v;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == 0) begin
      v = value & 32'h3FF;
      cur_width = (v < 1) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
    end else begin
      v = value & 32'h1FF;
      cur_height = (v < 1) ? 1 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
    end
    restart_maps();
  endtask

  // result checker with random back-pressure
  initial begin
    map_word_t e;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result with no command outstanding", $time);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (res_if.mask_word !== e.mask) begin
            $display("%0t: mask_word expected %h actual %h", $time, e.mask, res_if.mask_word);
            errors++;
          end
          if (res_if.dirty_word !== e.dirty) begin
            $display("%0t: dirty_word expected %h actual %h", $time, e.dirty,
                     res_if.dirty_word);
            errors++;
          end
          if (res_if.changes_pending !== e.pending) begin
            $display("%0t: changes_pending expected %b actual %b", $time, e.pending,
                     res_if.changes_pending);
            errors++;
          end
        end
      end
      res_if.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // point writes at the first and last pixels, with reads of the words they touch
  task automatic test_points();
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_MASK_PT, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_DIRTY_PT, 1, 0, 0, 0, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_MASK_PT, 511, 255, 0, 0, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 2047);
    send_fields(CMD_DIRTY_PT, 511, 255, 0, 0, 1, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 2047);
  endtask

  task automatic test_rects();
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    // empty rectangle still raises the flag
    send_fields(CMD_MASK_RECT, 5, 5, 0, 3, 0, 0);
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_DIRTY_RECT, 10, 2, 5, 0, 0, 0);
    // rectangle clipped at the right and bottom edges
    send_fields(CMD_MASK_RECT, 500, 250, 512, 256, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 2047);
    send_fields(CMD_DIRTY_RECT, 60, 1, 10, 2, 0, 9);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 9);
  endtask

  task automatic test_whole_maps();
    send_fields(CMD_MASK_ALL, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_DIRTY_ALL, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 1234);
    send_fields(CMD_DIRTY_ALL, 0, 0, 0, 0, 1, 0);
    send_fields(CMD_MASK_RECT, 0, 0, 512, 256, 1, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 1365);
  endtask

  // random commands sized to the current buffer
  task automatic test_random(int n);
    fill_cmd_t c;
    int unsigned r, last_word;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      last_word = (cur_width * cur_height - 1) / WORD_BITS;
      c.x = PX_W'($urandom_range(0, (cur_width + 3 > 511) ? 511 : cur_width + 3));
      c.y = PY_W'($urandom_range(0, (cur_height + 1 > 255) ? 255 : cur_height + 1));
      if ($urandom_range(9) == 0) begin
        c.w = BW_W'($urandom_range(0, 512));
        c.h = BH_W'($urandom_range(0, 256));
      end else begin
        c.w = BW_W'($urandom_range(0, 16));
        c.h = BH_W'($urandom_range(0, 8));
      end
      if ($urandom_range(19) == 0) c.x = PX_W'($urandom_range(0, 511));
      c.v = 1'($urandom_range(1));
      c.wi = ($urandom_range(7) == 0) ? WI_W'($urandom_range(0, 2047))
                                      : WI_W'($urandom_range(0, last_word));
      if (r < 12) c.op = CMD_MASK_PT;
      else if (r < 24) c.op = CMD_DIRTY_PT;
      else if (r < 40) c.op = CMD_MASK_RECT;
      else if (r < 52) c.op = CMD_DIRTY_RECT;
      else if (r < 54) c.op = CMD_MASK_ALL;
      else if (r < 56) c.op = CMD_DIRTY_ALL;
      else if (r < 62) c.op = CMD_CLEAR;
      else c.op = CMD_READ;
      send_cmd(c);
    end
  endtask

  // size sweep: saturating extremes and odd sizes
  task automatic test_sizes();
    write_reg(0, 32'd0);
    write_reg(1, 32'd0);
    test_random(110);
    write_reg(0, 32'h3FF);
    write_reg(1, 32'd1);
    test_random(110);
    write_reg(0, 32'hFFFF_F025);
    write_reg(1, 32'd5);
    calm = 1'b1;
    test_random(110);
    calm = 1'b0;
    write_reg(0, 32'd1);
    write_reg(1, 32'h1FF);
    test_random(110);
    write_reg(0, 32'd100);
    write_reg(1, 32'd77);
    test_random(110);
    write_reg(0, 32'd512);
    write_reg(1, 32'd256);
    test_random(110);
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.cmd = '0;
    cmd_if.pos_x = '0;
    cmd_if.pos_y = '0;
    cmd_if.box_width = '0;
    cmd_if.box_height = '0;
    cmd_if.fill_value = 1'b0;
    cmd_if.word_index = '0;
    cur_width = 512;
    cur_height = 256;
    restart_maps();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_points();
    test_rects();
    test_whole_maps();
    test_random(200);
    test_sizes();
    drain();
    repeat (20) @(posedge clk_i);
    if (expected_words.size() != 0) errors++;
    if (errors == 0) begin
      $display("bitmap_rect_fill regression: pass");
    end else begin
      $display("bitmap_rect_fill regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("bitmap_rect_fill regression: fail");
    $finish;
  end
endmodule
